// File: design/pts_pkg.sv
package pts_pkg;

  localparam int unsigned TaskSlots = 8;
  localparam int unsigned SlotIdxW  = $clog2(TaskSlots);
  localparam int unsigned SlotCntW  = $clog2(TaskSlots + 1);
  localparam int unsigned TickW     = 32;
  localparam int unsigned KindW     = 3;
  localparam int unsigned MaskW     = 8;

  typedef enum logic [KindW-1:0] {
    KIND_RUN      = 3'd0,
    KIND_REGISTER = 3'd1,
    KIND_CHANGE   = 3'd2,
    KIND_ENABLE   = 3'd3,
    KIND_DISABLE  = 3'd4,
    KIND_CLEAR    = 3'd5
  } kind_e;

  typedef struct packed {
    logic exec;
    logic drain;
  } pts_cmd_t;

  typedef struct packed {
    logic table_full;
  } pts_status_t;

endpackage

// File: design/pts_if.sv
interface pts_req_if;
  import pts_pkg::*;

  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [TickW-1:0]    cur_tick;
  logic [SlotIdxW-1:0] task_index;
  logic [TickW-1:0]    period;

  modport source (output valid, kind, cur_tick, task_index, period, input ready);
  modport sink   (input valid, kind, cur_tick, task_index, period, output ready);
endinterface

interface pts_rsp_if;
  import pts_pkg::*;

  logic             valid;
  logic             ready;
  logic [MaskW-1:0] fire_mask;
  logic             ok;
  logic [2:0]       slot;

  modport source (output valid, fire_mask, ok, slot, input ready);
  modport sink   (input valid, fire_mask, ok, slot, output ready);
endinterface

// File: design/periodic_task_scheduler_core.sv
// channel  dir  handshake    payload
// req_i    in   valid/ready  kind[2:0] cur_tick[31:0] task_index[2:0] period[31:0]
// rsp_o    out  valid/ready  fire_mask[7:0] ok slot[2:0]
//
// One request per cycle unless a held result stalls: every request finishes in the cycle it
// is accepted, with eight parallel subtract-compare units handling a run; the result lands in
// a single output register and is shown in the cycle after acceptance.
// A new request is taken while the held result is being taken in the same cycle.
// A stalled result holds the input off; nothing is lost.
// Asynchronous active-low reset empties the slot table and the output register.
module periodic_task_scheduler_core
  import pts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  pts_req_if.sink  req_i,
  pts_rsp_if.source rsp_o
);

  pts_cmd_t    cmd;
  pts_status_t status;

  pts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pts_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .kind_i       (req_i.kind),
    .cur_tick_i   (req_i.cur_tick),
    .task_index_i (req_i.task_index),
    .period_i     (req_i.period),
    .fire_mask_o  (rsp_o.fire_mask),
    .ok_o         (rsp_o.ok),
    .slot_o       (rsp_o.slot)
  );

endmodule

// File: design/pts_ctrl.sv
module pts_ctrl
  import pts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  pts_status_t status_i,
  output pts_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   exec;

  assign out_valid_o = (state_q == ST_FULL);
  assign in_ready_o  = (state_q == ST_EMPTY) || out_ready_i;
  assign exec        = in_valid_i && in_ready_o;
  assign cmd_o.exec  = exec;
  assign cmd_o.drain = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (exec) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (!exec && out_ready_i) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FULL && !out_ready_i) |-> !exec)
    else $error("result register overwritten while held");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.drain && !exec) |=> (state_q == ST_EMPTY))
    else $error("result not released after it was taken");

  a_full_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec |=> $stable(status_i.table_full))
    else $error("table fill changed without a request");

endmodule

// File: design/pts_datapath.sv
module pts_datapath
  import pts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pts_cmd_t            cmd_i,
  output pts_status_t         status_o,
  input  logic [KindW-1:0]    kind_i,
  input  logic [TickW-1:0]    cur_tick_i,
  input  logic [SlotIdxW-1:0] task_index_i,
  input  logic [TickW-1:0]    period_i,
  output logic [MaskW-1:0]    fire_mask_o,
  output logic                ok_o,
  output logic [2:0]          slot_o
);

  logic [TickW-1:0]    period_q   [TaskSlots];
  logic [TickW-1:0]    last_run_q [TaskSlots];
  logic [TaskSlots-1:0] enabled_q;
  logic [SlotCntW-1:0] used_q;

  logic [TaskSlots-1:0] live;
  logic [TaskSlots-1:0] due;
  logic [TickW-1:0]     elapsed [TaskSlots];
  logic                 known;
  logic                 full;

  logic [MaskW-1:0] fire_mask_d, fire_mask_q;
  logic             ok_d, ok_q;
  logic [2:0]       slot_d, slot_q;

  assign full  = (used_q >= SlotCntW'(TaskSlots));
  assign known = (SlotCntW'(task_index_i) < used_q);
  assign status_o.table_full = full;

  // one subtract-compare per slot, all in parallel
  always_comb begin
    for (int i = 0; i < TaskSlots; i++) begin
      live[i]    = (SlotCntW'(i) < used_q);
      elapsed[i] = cur_tick_i - last_run_q[i];
      due[i]     = live[i] && enabled_q[i] && (elapsed[i] >= period_q[i]);
    end
  end

  always_comb begin
    fire_mask_d = '0;
    ok_d        = 1'b0;
    slot_d      = '0;
    unique case (kind_i)
      KIND_RUN: begin
        for (int i = 0; i < TaskSlots && i < MaskW; i++) begin
          fire_mask_d[i] = due[i];
        end
        ok_d = 1'b1;
      end
      KIND_REGISTER: begin
        ok_d   = !full;
        slot_d = full ? 3'd0 : 3'(used_q);
      end
      KIND_CHANGE, KIND_ENABLE, KIND_DISABLE: ok_d = known;
      KIND_CLEAR: ok_d = 1'b1;
      default: ok_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TaskSlots; i++) begin
        period_q[i]   <= '0;
        last_run_q[i] <= '0;
      end
      enabled_q <= '0;
      used_q    <= '0;
    end else if (cmd_i.exec) begin
      unique case (kind_i)
        KIND_RUN: begin
          for (int i = 0; i < TaskSlots; i++) begin
            if (due[i]) last_run_q[i] <= cur_tick_i;
          end
        end
        KIND_REGISTER: begin
          if (!full) begin
            period_q[used_q[SlotIdxW-1:0]]   <= period_i;
            last_run_q[used_q[SlotIdxW-1:0]] <= cur_tick_i;
            enabled_q[used_q[SlotIdxW-1:0]]  <= 1'b1;
            used_q                           <= used_q + 1'b1;
          end
        end
        KIND_CHANGE: begin
          if (known) begin
            period_q[task_index_i]   <= period_i;
            last_run_q[task_index_i] <= cur_tick_i;
          end
        end
        KIND_ENABLE: begin
          if (known) begin
            enabled_q[task_index_i]  <= 1'b1;
            last_run_q[task_index_i] <= cur_tick_i;
          end
        end
        KIND_DISABLE: begin
          if (known) enabled_q[task_index_i] <= 1'b0;
        end
        KIND_CLEAR: begin
          for (int i = 0; i < TaskSlots; i++) begin
            period_q[i]   <= '0;
            last_run_q[i] <= '0;
          end
          enabled_q <= '0;
          used_q    <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fire_mask_q <= '0;
      ok_q        <= 1'b0;
      slot_q      <= '0;
    end else if (cmd_i.exec) begin
      fire_mask_q <= fire_mask_d;
      ok_q        <= ok_d;
      slot_q      <= slot_d;
    end
  end

  assign fire_mask_o = fire_mask_q;
  assign ok_o        = ok_q;
  assign slot_o      = slot_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SlotCntW'(TaskSlots))
    else $error("slot count beyond table size");

  a_enabled_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (enabled_q & ~live) == '0)
    else $error("unregistered slot enabled");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && kind_i == KIND_CLEAR) |=> (used_q == '0 && enabled_q == '0))
    else $error("clear left slots in the table");

endmodule

// File: dv/periodic_task_scheduler_core_test.sv
module periodic_task_scheduler_core_test;
  import pts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KindW-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KindW-1:0] KIND_RSVD7 = 3'd7;
  localparam int unsigned RandomReqs = 400;
  localparam int unsigned HoldAfter  = 150;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic [TickW-1:0]    cur_tick;
    logic [SlotIdxW-1:0] task_index;
    logic [TickW-1:0]    period;
  } sched_req_t;

  typedef struct packed {
    logic [MaskW-1:0] fire_mask;
    logic             ok;
    logic [2:0]       slot;
  } sched_rsp_t;

  logic clk_i;
  logic rst_ni;

  pts_req_if req_if ();
  pts_rsp_if rsp_if ();

  periodic_task_scheduler_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // scheduler table as predicted
  logic [TickW-1:0] sched_period [TaskSlots];
  logic [TickW-1:0] sched_last   [TaskSlots];
  logic             sched_en     [TaskSlots];
  int unsigned      sched_used;

  sched_req_t  stim_reqs[$];
  sched_rsp_t  predicted_rsps[$];
  sched_req_t  cur_req;
  int unsigned total_reqs;
  int unsigned reqs_accepted;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned hold_left;
  logic        hold_done;
  logic [TickW-1:0] stim_tick;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic void clear_table();
    for (int i = 0; i < TaskSlots; i++) begin
      sched_period[i] = '0;
      sched_last[i]   = '0;
      sched_en[i]     = 1'b0;
    end
    sched_used = 0;
  endfunction

  function automatic sched_rsp_t predict_schedule(sched_req_t r);
    sched_rsp_t res;
    logic [TickW-1:0] elapsed;
    logic known;
    res   = '0;
    known = (r.task_index < sched_used) && (r.task_index < TaskSlots);
    case (r.kind)
      KIND_RUN: begin
        for (int i = 0; i < sched_used && i < TaskSlots; i++) begin
          elapsed = r.cur_tick - sched_last[i];
          if (sched_en[i] && elapsed >= sched_period[i]) begin
            sched_last[i] = r.cur_tick;
            if (i < MaskW) res.fire_mask[i] = 1'b1;
          end
        end
        res.ok = 1'b1;
      end
      KIND_REGISTER: begin
        if (sched_used < TaskSlots) begin
          sched_period[sched_used] = r.period;
          sched_last[sched_used]   = r.cur_tick;
          sched_en[sched_used]     = 1'b1;
          res.slot = sched_used[2:0];
          res.ok   = 1'b1;
          sched_used++;
        end
      end
      KIND_CHANGE: begin
        if (known) begin
          sched_period[r.task_index] = r.period;
          sched_last[r.task_index]   = r.cur_tick;
          res.ok = 1'b1;
        end
      end
      KIND_ENABLE: begin
        if (known) begin
          sched_en[r.task_index]   = 1'b1;
          sched_last[r.task_index] = r.cur_tick;
          res.ok = 1'b1;
        end
      end
      KIND_DISABLE: begin
        if (known) begin
          sched_en[r.task_index] = 1'b0;
          res.ok = 1'b1;
        end
      end
      KIND_CLEAR: begin
        clear_table();
        res.ok = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int unsigned cur_phase();
    return (reqs_accepted / 40) % 4;
  endfunction

  task automatic add_req(input logic [KindW-1:0] kind, input logic [TickW-1:0] tick,
                         input logic [SlotIdxW-1:0] idx, input logic [TickW-1:0] period);
    sched_req_t r;
    r.kind       = kind;
    r.cur_tick   = tick;
    r.task_index = idx;
    r.period     = period;
    stim_reqs.push_back(r);
  endtask

  function automatic logic [TickW-1:0] next_tick();
    if ($urandom_range(0, 99) < 3) stim_tick = $urandom();
    else stim_tick = stim_tick + $urandom_range(0, 12);
    return stim_tick;
  endfunction

  function automatic logic [TickW-1:0] rand_period();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(0, 30);
    if (pick < 9) return $urandom_range(0, 500);
    return $urandom();
  endfunction

  task automatic add_random_reqs();
    int unsigned added;
    int unsigned pick;
    logic [KindW-1:0] kind;
    added = 0;
    stim_tick = 32'hFFFF_FFF0;
    while (added < RandomReqs) begin
      if ($urandom_range(0, 3) != 0) begin
        add_req(KIND_CLEAR, next_tick(), SlotIdxW'($urandom_range(0, 7)), $urandom());
        added++;
      end
      repeat ($urandom_range(1, TaskSlots + 1)) begin
        add_req(KIND_REGISTER, next_tick(), SlotIdxW'($urandom_range(0, 7)),
                rand_period());
        added++;
      end
      repeat ($urandom_range(10, 50)) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) kind = KIND_RUN;
        else if (pick < 65) kind = KIND_CHANGE;
        else if (pick < 73) kind = KIND_ENABLE;
        else if (pick < 81) kind = KIND_DISABLE;
        else if (pick < 88) kind = KIND_REGISTER;
        else if (pick < 91) kind = KIND_CLEAR;
        else if (pick < 95) kind = KIND_RSVD6;
        else kind = KIND_RSVD7;
        add_req(kind, next_tick(), SlotIdxW'($urandom_range(0, 7)), rand_period());
        added++;
      end
    end
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        predicted_rsps.push_back(predict_schedule(cur_req));
        reqs_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (stim_reqs.size() > 0 &&
            $urandom_range(0, 99) >= (cur_phase() == 1 ? 62 : cur_phase() == 3 ? 17 : 0)) begin
          cur_req = stim_reqs.pop_front();
          req_if.valid      <= 1'b1;
          req_if.kind       <= cur_req.kind;
          req_if.cur_tick   <= cur_req.cur_tick;
          req_if.task_index <= cur_req.task_index;
          req_if.period     <= cur_req.period;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response ready, with one long hold-off to back up the input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && reqs_accepted >= HoldAfter) begin
        hold_done    <= 1'b1;
        hold_left    <= HoldCycles;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= $urandom_range(0, 99) >=
                        (cur_phase() == 2 ? 62 : cur_phase() == 3 ? 17 : 0);
      end
    end
  end

  // response monitor
  always @(posedge clk_i) begin : check_rsps
    sched_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (predicted_rsps.size() == 0) begin
        $display("%0t: unexpected response mask=%h ok=%b slot=%0d", $time,
                 rsp_if.fire_mask, rsp_if.ok, rsp_if.slot);
        mismatches++;
      end else begin
        want = predicted_rsps.pop_front();
        if (rsp_if.fire_mask !== want.fire_mask) begin
          $display("%0t: fire_mask expected %h actual %h", $time, want.fire_mask,
                   rsp_if.fire_mask);
          mismatches++;
        end
        if (rsp_if.ok !== want.ok) begin
          $display("%0t: ok expected %b actual %b", $time, want.ok, rsp_if.ok);
          mismatches++;
        end
        if (rsp_if.slot !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, rsp_if.slot);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.kind       = KIND_RUN;
    req_if.cur_tick   = '0;
    req_if.task_index = '0;
    req_if.period     = '0;
    rsp_if.ready      = 1'b0;
    reqs_accepted     = 0;
    mismatches        = 0;
    idle_cycles       = 0;
    hold_left         = 0;
    hold_done         = 1'b0;
    clear_table();

    // empty table, unregistered slot
    add_req(KIND_RUN,      32'h0000_0000, 3'd0, 32'h0000_0000);
    add_req(KIND_DISABLE,  32'h0000_0001, 3'd0, 32'hFFFF_FFFF);
    // fill every slot, then one more
    add_req(KIND_REGISTER, 32'hFFFF_FFFF, 3'd7, 32'h0000_0000);
    add_req(KIND_REGISTER, 32'h0000_0000, 3'd0, 32'hFFFF_FFFF);
    add_req(KIND_REGISTER, 32'hFFFF_FFF0, 3'd5, 32'h0000_0020);
    add_req(KIND_REGISTER, 32'hFFFF_FFF8, 3'd2, 32'h0000_0008);
    add_req(KIND_REGISTER, 32'h8000_0000, 3'd1, 32'h7FFF_FFFF);
    add_req(KIND_REGISTER, 32'h0000_0004, 3'd3, 32'h0000_0001);
    add_req(KIND_REGISTER, 32'h0000_0005, 3'd4, 32'h8000_0000);
    add_req(KIND_REGISTER, 32'h0000_0006, 3'd6, 32'h0000_0003);
    add_req(KIND_REGISTER, 32'h0000_0007, 3'd7, 32'h0000_0005);
    // elapsed time wraps past zero
    add_req(KIND_RUN,      32'h0000_0010, 3'd0, 32'h0000_0000);
    add_req(KIND_CHANGE,   32'h0000_0011, 3'd7, 32'h0000_0000);
    add_req(KIND_ENABLE,   32'h0000_0012, 3'd1, 32'h0000_0000);
    add_req(KIND_DISABLE,  32'h0000_0013, 3'd2, 32'h0000_0000);
    add_req(KIND_DISABLE,  32'h0000_0014, 3'd2, 32'h0000_0000);
    add_req(KIND_RUN,      32'hFFFF_FFFF, 3'd0, 32'h0000_0000);
    add_req(KIND_ENABLE,   32'hFFFF_FFFF, 3'd2, 32'h0000_0000);
    add_req(KIND_RSVD6,    32'h0000_0020, 3'd0, 32'h0000_0001);
    add_req(KIND_RSVD7,    32'h0000_0021, 3'd7, 32'hFFFF_FFFF);
    add_req(KIND_CLEAR,    32'h0000_0022, 3'd0, 32'h0000_0000);
    add_req(KIND_CHANGE,   32'h0000_0023, 3'd0, 32'h0000_0004);
    add_req(KIND_ENABLE,   32'h0000_0024, 3'd3, 32'h0000_0000);
    add_req(KIND_REGISTER, 32'h0000_0025, 3'd0, 32'h0000_0000);
    add_req(KIND_RUN,      32'h0000_0025, 3'd0, 32'h0000_0000);
    add_random_reqs();
    total_reqs = stim_reqs.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (reqs_accepted < total_reqs || predicted_rsps.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && predicted_rsps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pts_pkg.sv
design/pts_if.sv
design/pts_ctrl.sv
design/pts_datapath.sv
design/periodic_task_scheduler_core.sv
dv/periodic_task_scheduler_core_test.sv
